[sv/irda_sir_pkg.sv]
// ----------------------------------------------------------------------------
// irda_sir_pkg
// Shared types, constants and the frame check update for the SIR wrapper.
// ----------------------------------------------------------------------------
package irda_sir_pkg;

  localparam logic [7:0]  FLAG_START = 8'hC0;
  localparam logic [7:0]  FLAG_END   = 8'hC1;
  localparam logic [7:0]  ESC_MARK   = 8'h7D;
  localparam logic [7:0]  ESC_XOR    = 8'h20;
  localparam logic [15:0] CHECK_SEED = 16'hFFFF;
  localparam logic [15:0] CHECK_POLY = 16'h8408;
  localparam logic [5:0]  FLAGS_MIN  = 6'd1;
  localparam logic [5:0]  FLAGS_MAX  = 6'd48;
  localparam logic [5:0]  FLAGS_RST  = 6'd10;

  // Which part of the frame the emitter produces next.
  typedef enum logic [2:0] {
    PH_FLAG,
    PH_DATA,
    PH_FCS_LO,
    PH_FCS_HI,
    PH_END
  } phase_t;

  // One held payload beat handed from the input stage to the emitter.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } item_t;

  // Reflected CRC-CCITT, one byte folded in, LSB first.
  function automatic logic [15:0] check_update(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CHECK_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == FLAG_START) || (b == FLAG_END) || (b == ESC_MARK);
  endfunction

endpackage

[sv/irda_sir_in_stage.sv]
// ----------------------------------------------------------------------------
// irda_sir_in_stage
// Input register: holds one payload beat until the emitter has used it.
// ----------------------------------------------------------------------------
module irda_sir_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 in_tlast,
  input  logic                 consume,
  output irda_sir_pkg::item_t  item
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic       last_r;

  // Free when empty or when the held beat finishes this cycle.
  assign in_tready = !valid_r || consume;
  assign valid_nxt = (in_tvalid && in_tready) ? 1'b1 : (consume ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign item.valid = valid_r;
  assign item.data  = data_r;
  assign item.last  = last_r;

endmodule

[sv/irda_sir_emit.sv]
// ----------------------------------------------------------------------------
// irda_sir_emit
// Frame sequencer: one line byte per cycle to the output register, bar stalls.
// ----------------------------------------------------------------------------
module irda_sir_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  irda_sir_pkg::item_t  item,
  input  logic [5:0]           flag_count,
  output logic                 consume,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  irda_sir_pkg::phase_t phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [7:0]  obyte_r;
  logic        olast_r;

  logic        fire;
  logic [5:0]  flags_eff;
  logic [7:0]  sel_byte;
  logic        sel_esc;
  logic        byte_done;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic [15:0] crc_fcs;

  assign fire = item.valid && (!ovalid_r || out_tready);

  always_comb begin
    flags_eff = flag_count;
    if (flag_count < irda_sir_pkg::FLAGS_MIN) begin
      flags_eff = irda_sir_pkg::FLAGS_MIN;
    end else if (flag_count > irda_sir_pkg::FLAGS_MAX) begin
      flags_eff = irda_sir_pkg::FLAGS_MAX;
    end
  end

  assign crc_fcs = ~crc_r;

  always_comb begin
    case (phase_r)
      irda_sir_pkg::PH_DATA:   sel_byte = item.data;
      irda_sir_pkg::PH_FCS_LO: sel_byte = crc_fcs[7:0];
      irda_sir_pkg::PH_FCS_HI: sel_byte = crc_fcs[15:8];
      default:                 sel_byte = item.data;
    endcase
  end

  assign sel_esc   = irda_sir_pkg::needs_escape(sel_byte);
  // An escaped byte finishes on its second line byte, after the escape mark.
  assign byte_done = !sel_esc || esc_r;

  // Next-state logic.
  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    if (fire) begin
      case (phase_r)
        irda_sir_pkg::PH_FLAG: begin
          if (cnt_r == flags_eff - 6'd1) begin
            cnt_nxt   = 6'd0;
            phase_nxt = irda_sir_pkg::PH_DATA;
          end else begin
            cnt_nxt = cnt_r + 6'd1;
          end
        end
        irda_sir_pkg::PH_DATA: begin
          esc_nxt = !byte_done;
          if (byte_done) begin
            crc_nxt = irda_sir_pkg::check_update(crc_r, item.data);
            if (item.last) begin
              phase_nxt = irda_sir_pkg::PH_FCS_LO;
            end
          end
        end
        irda_sir_pkg::PH_FCS_LO: begin
          esc_nxt = !byte_done;
          if (byte_done) begin
            phase_nxt = irda_sir_pkg::PH_FCS_HI;
          end
        end
        irda_sir_pkg::PH_FCS_HI: begin
          esc_nxt = !byte_done;
          if (byte_done) begin
            phase_nxt = irda_sir_pkg::PH_END;
          end
        end
        irda_sir_pkg::PH_END: begin
          crc_nxt   = irda_sir_pkg::CHECK_SEED;
          phase_nxt = irda_sir_pkg::PH_FLAG;
        end
        default: begin
          phase_nxt = irda_sir_pkg::PH_FLAG;
        end
      endcase
    end
  end

  // Output logic.
  always_comb begin
    emit_byte = irda_sir_pkg::FLAG_START;
    emit_last = 1'b0;
    case (phase_r)
      irda_sir_pkg::PH_FLAG: begin
        emit_byte = irda_sir_pkg::FLAG_START;
      end
      irda_sir_pkg::PH_DATA,
      irda_sir_pkg::PH_FCS_LO,
      irda_sir_pkg::PH_FCS_HI: begin
        if (!sel_esc) begin
          emit_byte = sel_byte;
        end else if (!esc_r) begin
          emit_byte = irda_sir_pkg::ESC_MARK;
        end else begin
          emit_byte = sel_byte ^ irda_sir_pkg::ESC_XOR;
        end
        emit_last = (phase_r == irda_sir_pkg::PH_DATA) && byte_done && !item.last;
      end
      irda_sir_pkg::PH_END: begin
        emit_byte = irda_sir_pkg::FLAG_END;
        emit_last = 1'b1;
      end
      default: begin
        emit_byte = irda_sir_pkg::FLAG_START;
      end
    endcase
  end

  assign consume    = fire && emit_last;
  assign ovalid_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : ovalid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= irda_sir_pkg::PH_FLAG;
      esc_r    <= 1'b0;
      cnt_r    <= 6'd0;
      crc_r    <= irda_sir_pkg::CHECK_SEED;
      ovalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      esc_r    <= esc_nxt;
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      obyte_r <= emit_byte;
      olast_r <= emit_last;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_byte   = obyte_r;
  assign out_last   = olast_r;

endmodule

[sv/irda_sir_frame_wrapper_top.sv]
// ----------------------------------------------------------------------------
// irda_sir_frame_wrapper_top
// IrDA SIR asynchronous frame wrapper with the 16-bit FCS and byte stuffing.
// ----------------------------------------------------------------------------
// Data path: a beat is captured in the input register at its accepting edge;
// its line bytes then pass through the output register to out_tdata.
// Throughput: one line byte per cycle while a beat is held and the receiver
// does not stall, set by the single output register; a payload beat costs
// one byte, two when escaped, plus start flags, FCS bytes and end flag per frame.
// Reset (rst_n low, synchronous): no frame open, FCS seeded 0xFFFF, 10 flags.
// ----------------------------------------------------------------------------
module irda_sir_frame_wrapper_top (
  input  logic       clk,
  input  logic       rst_n,
  // Start flag count register.
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data,   // start_flag_count
  // Payload beats.
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] data_byte
  input  logic       in_tlast,      // last_byte
  // Wrapped line stream.
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] out_byte
  output logic       out_tlast      // run_last: final byte caused by a beat
);

  // The start flag count is sampled by the emitter whenever it sends flags.
  // Zero is sent as one flag and anything above 48 as 48; the emitter does
  // the clamping so the register keeps the raw written value.
  logic [5:0] flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= irda_sir_pkg::FLAGS_RST;
    end else if (cfg_wr_en) begin
      flags_r <= cfg_wr_data;
    end
  end

  irda_sir_pkg::item_t item;
  logic                consume;

  // The input register is freed in the same cycle that the emitter produces
  // the final byte of the held beat, so back-to-back payload beats of an
  // open frame move at one line byte per cycle unless the receiver stalls.
  irda_sir_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .consume   (consume),
    .item      (item)
  );

  // The emitter walks the frame sections: start flags on the first beat of
  // a frame, the stuffed payload byte, and after the last beat the two
  // complemented FCS bytes (low first, each stuffed) and the end flag.
  irda_sir_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .flag_count (flags_r),
    .consume    (consume),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IrDA SIR frame wrapper: payload beats are sent
// in frames, every line byte is predicted here and checked in order.
// ----------------------------------------------------------------------------
module tb_top;

  // Run bounds. The limit covers the worst case of every beat opening a
  // frame with 48 flags and stuffed FCS bytes, under random stalls.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BEATS = 340;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  // One payload beat waiting to be offered to the block.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } payload_beat_t;

  // One expected line byte and whether it closes the run of its beat.
  typedef struct {
    logic [7:0] line_byte;
    logic       run_end;
  } line_beat_t;

  // Ports. Every input is known from time zero.
  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  logic [5:0] cfg_wr_data = '0;
  logic       in_tvalid   = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata    = '0;
  logic       in_tlast    = 1'b0;
  logic       out_tvalid;
  logic       out_tready  = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  // Stimulus and expectation stores.
  payload_beat_t payload_q[$];
  line_beat_t    line_q[$];

  // Private copy of the block's state and its register.
  logic [5:0]  flag_count_reg = irda_sir_pkg::FLAGS_RST;
  logic        in_frame       = 1'b0;
  logic [15:0] fcs_acc        = irda_sir_pkg::CHECK_SEED;

  // Idle rates in percent, changed per phase by the sequencer.
  int unsigned send_gap_pct   = 15;
  int unsigned recv_stall_pct = 15;

  // Long receiver hold-off, armed once by the sequencer.
  logic        hold_arm  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  // Bookkeeping.
  int unsigned beats_queued   = 0;
  int unsigned beats_accepted = 0;
  int unsigned bytes_checked  = 0;
  int unsigned frames_closed  = 0;
  int unsigned stuffed_bytes  = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;

  irda_sir_frame_wrapper_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Frame check and byte stuffing, as the line sees them.
  // --------------------------------------------------------------------------

  // Reflected CRC-CCITT folded one data bit at a time, LSB first.
  function automatic logic [15:0] fold_fcs(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ b[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ irda_sir_pkg::CHECK_POLY;
      end
    end
    return crc;
  endfunction

  function automatic logic is_stuffed(input logic [7:0] b);
    return (b == irda_sir_pkg::FLAG_START) || (b == irda_sir_pkg::FLAG_END) ||
           (b == irda_sir_pkg::ESC_MARK);
  endfunction

  // Payload and FCS bytes that collide with a flag or the escape are sent as
  // the escape followed by the byte with bit 5 flipped.
  function automatic void push_line_byte(input logic [7:0] b);
    if (is_stuffed(b)) begin
      line_q.push_back('{irda_sir_pkg::ESC_MARK, 1'b0});
      line_q.push_back('{b ^ irda_sir_pkg::ESC_XOR, 1'b0});
      stuffed_bytes++;
    end else begin
      line_q.push_back('{b, 1'b0});
    end
  endfunction

  // Expected line bytes for one accepted payload beat. The flag count is
  // read when a frame opens, so a write in the middle of a frame only takes
  // effect on the next one.
  task automatic predict_line_bytes(input logic [7:0] d, input logic l);
    logic [5:0]  flags;
    logic [15:0] fcs;
    if (!in_frame) begin
      flags = flag_count_reg;
      if (flags < irda_sir_pkg::FLAGS_MIN) begin
        flags = irda_sir_pkg::FLAGS_MIN;
      end
      if (flags > irda_sir_pkg::FLAGS_MAX) begin
        flags = irda_sir_pkg::FLAGS_MAX;
      end
      repeat (flags) line_q.push_back('{irda_sir_pkg::FLAG_START, 1'b0});
      fcs_acc  = irda_sir_pkg::CHECK_SEED;
      in_frame = 1'b1;
    end
    push_line_byte(d);
    fcs_acc = fold_fcs(fcs_acc, d);
    if (l) begin
      fcs = ~fcs_acc;
      push_line_byte(fcs[7:0]);
      push_line_byte(fcs[15:8]);
      line_q.push_back('{irda_sir_pkg::FLAG_END, 1'b0});
      in_frame = 1'b0;
      fcs_acc  = irda_sir_pkg::CHECK_SEED;
      frames_closed++;
    end
    line_q[line_q.size() - 1].run_end = 1'b1;
  endtask

  // Finds a two-byte frame whose FCS has a byte that needs stuffing, in the
  // low or the high position, so that both FCS escape paths get exercised.
  function automatic logic [15:0] find_stuffed_fcs(input logic want_hi);
    logic [15:0] fcs;
    for (int h = 0; h < 256; h++) begin
      for (int t = 0; t < 256; t++) begin
        fcs = ~fold_fcs(fold_fcs(irda_sir_pkg::CHECK_SEED, h[7:0]), t[7:0]);
        if (is_stuffed(want_hi ? fcs[15:8] : fcs[7:0])) begin
          return {h[7:0], t[7:0]};
        end
      end
    end
    return 16'h0000;
  endfunction

  // --------------------------------------------------------------------------
  // Sequencer helpers.
  // --------------------------------------------------------------------------

  // Random payload byte, with the three colliding values well represented.
  function automatic logic [7:0] rand_payload_byte();
    case ($urandom_range(9))
      0:       return irda_sir_pkg::FLAG_START;
      1:       return irda_sir_pkg::FLAG_END;
      2:       return irda_sir_pkg::ESC_MARK;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic void push_beat(input logic [7:0] d, input logic l);
    payload_q.push_back('{d, l});
    beats_queued++;
  endfunction

  // A frame of random content; the last beat is marked only when closing.
  function automatic void push_frame(input int unsigned len, input logic close);
    for (int unsigned i = 0; i < len; i++) begin
      push_beat(rand_payload_byte(), close && (i == len - 1));
    end
  endfunction

  // The register is written only while nothing is in flight.
  task automatic write_flag_count(input logic [5:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    flag_count_reg  = v;
  endtask

  // Every queued beat accepted and every predicted byte seen. Each beat
  // produces at least one byte, so the block is idle once this holds.
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (beats_accepted != beats_queued || line_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Payload driver. A beat is accepted on an edge with tvalid and tready
  // both high; the prediction is made at that edge. A new beat is put up
  // only when the bus is empty or the current beat has just gone, and
  // tvalid gets at most one assignment per edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_line_bytes(in_tdata, in_tlast);
        beats_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (payload_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= payload_q[0].data;
          in_tlast  <= payload_q[0].last;
          payload_q.delete(0);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver hold-off counter. Once armed it keeps tready low for a long
  // stretch so that the block backs up into its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_arm && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Line monitor. Each accepted line beat is compared with the oldest
  // expectation, byte and run end both.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (line_q.size() == 0) begin
          $error("unexpected line beat: out_byte %02h, run_last %0b", out_tdata, out_tlast);
          fail_count++;
        end else begin
          if (out_tdata !== line_q[0].line_byte) begin
            $error("out_byte: expected %02h, actual %02h", line_q[0].line_byte, out_tdata);
            fail_count++;
          end
          if (out_tlast !== line_q[0].run_end) begin
            $error("run_last: expected %0b, actual %0b", line_q[0].run_end, out_tlast);
            fail_count++;
          end
          line_q.delete(0);
          bytes_checked++;
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: a hang or a lost byte ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d line bytes outstanding",
               cycle_count, line_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: reset, a directed opening, then random phases. Between
  // phases the bench drains and may rewrite the flag count.
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] pair;
    int unsigned rand_beats;
    int unsigned phase_beats;
    int unsigned phase;
    int unsigned len;
    int unsigned nframes;
    logic [5:0]  count;

    rand_beats = 0;
    phase      = 0;

    // Synchronous reset, held low from time zero and released once.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset flag count: single-byte frames at both data extremes, then a
    // frame made of every colliding byte, the XOR value and the flipped escape.
    push_beat(8'h00, 1'b1);
    push_beat(8'hFF, 1'b1);
    push_beat(irda_sir_pkg::FLAG_START, 1'b0);
    push_beat(irda_sir_pkg::FLAG_END, 1'b0);
    push_beat(irda_sir_pkg::ESC_MARK, 1'b0);
    push_beat(irda_sir_pkg::ESC_XOR, 1'b0);
    push_beat(8'h5D, 1'b1);
    wait_drained();

    // A zero count still gives one start flag; FCS bytes that need stuffing.
    write_flag_count(6'd0);
    pair = find_stuffed_fcs(1'b0);
    push_beat(pair[15:8], 1'b0);
    push_beat(pair[7:0], 1'b1);
    pair = find_stuffed_fcs(1'b1);
    push_beat(pair[15:8], 1'b0);
    push_beat(pair[7:0], 1'b1);
    wait_drained();

    // Counts above the ceiling saturate.
    write_flag_count(6'd63);
    push_beat(8'hAA, 1'b1);
    wait_drained();

    // At the ceiling, then a frame left open across a register write: the
    // new count must wait for the next frame.
    write_flag_count(irda_sir_pkg::FLAGS_MAX);
    push_beat(8'h55, 1'b1);
    push_beat(8'h01, 1'b0);
    push_beat(8'h02, 1'b0);
    wait_drained();
    write_flag_count(irda_sir_pkg::FLAGS_MIN);
    push_beat(8'h03, 1'b1);
    push_beat(8'h04, 1'b1);
    wait_drained();

    write_flag_count(irda_sir_pkg::FLAGS_MAX + 6'd1);
    push_beat(8'h80, 1'b1);
    wait_drained();

    // Random phases of well-formed frames with random content. Now and then
    // a phase ends inside a frame, which the next phase then carries on.
    while (rand_beats < RANDOM_BEATS) begin
      case ($urandom_range(7))
        0:       count = 6'd0;
        1:       count = irda_sir_pkg::FLAGS_MIN;
        2:       count = irda_sir_pkg::FLAGS_MAX;
        3:       count = 6'd63;
        default: count = 6'($urandom_range(63));
      endcase
      write_flag_count(count);

      phase_beats    = beats_queued;
      send_gap_pct   = 15;
      recv_stall_pct = 15;

      if (phase == 2) begin
        // A long stretch with neither side idling.
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        while (beats_queued - phase_beats < 40) begin
          push_frame($urandom_range(1, 10), 1'b1);
        end
      end else if (phase == 4) begin
        // The receiver holds off while the sender keeps offering beats, so
        // the block fills and drops in_tready.
        send_gap_pct = 0;
        hold_arm    <= 1'b1;
        push_frame(24, 1'b1);
        push_frame(24, 1'b1);
      end else begin
        nframes = $urandom_range(1, 4);
        for (int unsigned f = 0; f < nframes; f++) begin
          len = ($urandom_range(7) == 0) ? $urandom_range(20, 40)
                                         : $urandom_range(1, 10);
          push_frame(len, !(f == nframes - 1 && $urandom_range(4) == 0));
        end
      end

      rand_beats += beats_queued - phase_beats;
      wait_drained();
      phase++;
    end

    // Let anything stray leave the block before closing.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (line_q.size() != 0) begin
      $error("%0d expected line bytes never arrived", line_q.size());
      fail_count++;
    end

    $display("Sent %0d payload beats in %0d closed frames over %0d random phases;",
             beats_accepted, frames_closed, phase);
    $display("checked %0d line bytes, %0d of them stuffed, with a %0d-cycle hold-off.",
             bytes_checked, stuffed_bytes, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
sv/irda_sir_pkg.sv
sv/irda_sir_in_stage.sv
sv/irda_sir_emit.sv
sv/irda_sir_frame_wrapper_top.sv
verif/tb_top.sv
